// ----- rtl/affine_matrix_chain_multiply_defines.svh -----
// Assertion macros shared by the affine matrix chain multiplier RTL.
`ifndef AFFINE_MATRIX_CHAIN_MULTIPLY_DEFINES_SVH
`define AFFINE_MATRIX_CHAIN_MULTIPLY_DEFINES_SVH
`ifndef ASSERT_OFF
`define AMCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AMCM_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define AMCM_ASSERT(lbl, prop, msg)
`define AMCM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/amcm_pkg.sv -----
// Package with constants, microcode types and the control program of the chain multiplier.
package amcm_pkg;

	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int ELEM_WIDTH      = 32;
	localparam int INDEX_WIDTH     = 4;
	localparam int MAT_SIZE        = 12;
	localparam int ROWS            = 3;
	localparam int COLS            = 4;
	localparam int FIX_SCALE       = 1000;
	localparam int REM_WIDTH       = 10;
	localparam int DIGIT_BITS      = 8;
	localparam int MUL_WIDTH       = 32;
	localparam int PC_WIDTH        = 4;

	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_COPY      = 4'd1,
		OP_INIT      = 4'd2,
		OP_LOAD      = 4'd3,
		OP_MUL       = 4'd4,
		OP_ACC       = 4'd5,
		OP_DIV       = 4'd6,
		OP_TERM      = 4'd7,
		OP_OFS       = 4'd8,
		OP_STORE     = 4'd9,
		OP_EMIT_INIT = 4'd10,
		OP_EMIT      = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_MUL_MORE  = 3'd2,
		C_DIV_MORE  = 3'd3,
		C_K_MORE    = 3'd4,
		C_ENT_MORE  = 3'd5,
		C_NOT_LAST  = 3'd6,
		C_EMIT_MORE = 3'd7
	} cond_t;

	typedef logic [PC_WIDTH-1:0] pc_t;

	localparam pc_t S_IDLE  = 4'd0;
	localparam pc_t S_COPY  = 4'd1;
	localparam pc_t S_MUL   = 4'd2;
	localparam pc_t S_LOAD  = 4'd3;
	localparam pc_t S_MULS  = 4'd4;
	localparam pc_t S_ACCS  = 4'd5;
	localparam pc_t S_DIVS  = 4'd6;
	localparam pc_t S_TERM  = 4'd7;
	localparam pc_t S_OFS   = 4'd8;
	localparam pc_t S_STORE = 4'd9;
	localparam pc_t S_CHECK = 4'd10;
	localparam pc_t S_EMIT  = 4'd11;
	localparam pc_t S_DONE  = 4'd12;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic mul_more;
		logic div_more;
		logic k_more;
		logic ent_more;
		logic emit_more;
		logic last;
	} stat_t;

	function automatic ctrl_t rom_word(pc_t pc);
		ctrl_t w;
		case (pc)
			S_IDLE:  w = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_IDLE};
			S_COPY:  w = '{op: OP_COPY,      cond: C_ALWAYS,    target: S_CHECK};
			S_MUL:   w = '{op: OP_INIT,      cond: C_NEXT,      target: S_IDLE};
			S_LOAD:  w = '{op: OP_LOAD,      cond: C_NEXT,      target: S_IDLE};
			S_MULS:  w = '{op: OP_MUL,       cond: C_NEXT,      target: S_IDLE};
			S_ACCS:  w = '{op: OP_ACC,       cond: C_MUL_MORE,  target: S_MULS};
			S_DIVS:  w = '{op: OP_DIV,       cond: C_DIV_MORE,  target: S_DIVS};
			S_TERM:  w = '{op: OP_TERM,      cond: C_K_MORE,    target: S_LOAD};
			S_OFS:   w = '{op: OP_OFS,       cond: C_NEXT,      target: S_IDLE};
			S_STORE: w = '{op: OP_STORE,     cond: C_ENT_MORE,  target: S_LOAD};
			S_CHECK: w = '{op: OP_EMIT_INIT, cond: C_NOT_LAST,  target: S_IDLE};
			S_EMIT:  w = '{op: OP_EMIT,      cond: C_EMIT_MORE, target: S_EMIT};
			S_DONE:  w = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_IDLE};
			default: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/amcm_seq.sv -----
// Microcode sequencer: program counter, control store lookup and jump logic.
module amcm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic            go_copy,
	input  amcm_pkg::stat_t stat,
	output amcm_pkg::ctrl_t ctrl,
	output logic            busy
);

	amcm_pkg::pc_t pc_q;
	logic          take;

	assign ctrl = amcm_pkg::rom_word(pc_q);
	assign busy = (pc_q != amcm_pkg::S_IDLE);

	always_comb begin
		case (ctrl.cond)
			amcm_pkg::C_NEXT:      take = 1'b0;
			amcm_pkg::C_ALWAYS:    take = 1'b1;
			amcm_pkg::C_MUL_MORE:  take = stat.mul_more;
			amcm_pkg::C_DIV_MORE:  take = stat.div_more;
			amcm_pkg::C_K_MORE:    take = stat.k_more;
			amcm_pkg::C_ENT_MORE:  take = stat.ent_more;
			amcm_pkg::C_NOT_LAST:  take = !stat.last;
			amcm_pkg::C_EMIT_MORE: take = stat.emit_more;
			default:               take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= amcm_pkg::S_IDLE;
		end else if (!busy && go) begin
			pc_q <= go_copy ? amcm_pkg::S_COPY : amcm_pkg::S_MUL;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= amcm_pkg::PC_WIDTH'(pc_q + 1'b1);
		end
	end

endmodule

// ----- rtl/affine_matrix_chain_multiply.sv -----
// Top level of the affine matrix chain multiplier: element intake, datapath and output register.
//
// Usage: one 32-bit matrix element is accepted per cycle on a rising edge with start high
// and busy low, in row-major order; an internal counter frames every 12 beats as one matrix.
// first_matrix and last_matrix are sampled only on the twelfth beat of a matrix.
// Eleven of the twelve beats are taken back to back; the twelfth raises busy while the
// matrix is consumed. A first matrix is copied into the accumulator. A chained matrix
// forms each product in NC = ceil(ENTRY_WIDTH/32) chunks of 32 bits and divides it by 1000
// as a DW-bit value, where DW is ENTRY_WIDTH + 31 rounded up to a multiple of 8, using the
// single 32x32 multiplier and the divide-by-1000 unit, which retires 8 quotient bits a cycle,
// both sequenced by the control program.
// When the matrix was marked last, 12 result beats follow on entry, entry_index and
// last_entry, one per cycle, each marked by strobe for exactly one cycle; busy drops in the
// cycle after the final beat. The receiver cannot stall, so results are never held.
// Reset clears the accumulator to zero, the element counter and the sequencer.
module affine_matrix_chain_multiply #(
	parameter int ENTRY_WIDTH = amcm_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [amcm_pkg::ELEM_WIDTH-1:0]   element,
	input  logic                                     first_matrix,
	input  logic                                     last_matrix,
	output logic                                     strobe,
	output logic signed [amcm_pkg::ELEM_WIDTH-1:0]   entry,
	output logic        [amcm_pkg::INDEX_WIDTH-1:0]  entry_index,
	output logic                                     last_entry
);

	`include "affine_matrix_chain_multiply_defines.svh"

	localparam int EW     = ENTRY_WIDTH;
	localparam int OW     = amcm_pkg::ELEM_WIDTH;
	localparam int IW     = amcm_pkg::INDEX_WIDTH;
	localparam int MW     = amcm_pkg::MUL_WIDTH;
	localparam int DB     = amcm_pkg::DIGIT_BITS;
	localparam int RW     = amcm_pkg::REM_WIDTH;
	localparam int TW     = RW + 1;
	localparam int NC     = (EW + MW - 1) / MW;
	localparam int AW     = NC * MW;
	localparam int DW     = ((EW + MW - 1 + DB - 1) / DB) * DB;
	localparam int DSTEPS = DW / DB;
	localparam int DCW    = $clog2(DSTEPS);
	localparam int CCW    = (NC > 1) ? $clog2(NC) : 1;
	localparam int SW     = EW + 24;
	localparam int XW     = (EW > OW) ? EW : OW;

	amcm_pkg::ctrl_t ctrl;
	amcm_pkg::stat_t stat;

	logic signed [OW-1:0] inc_q [amcm_pkg::MAT_SIZE];
	logic signed [EW-1:0] acc_q [amcm_pkg::MAT_SIZE];
	logic signed [EW-1:0] row_q [amcm_pkg::ROWS];
	logic        [IW-1:0] cnt_q;
	logic                 last_q;
	logic        [1:0]    r_q;
	logic        [1:0]    c_q;
	logic        [1:0]    k_q;
	logic        [IW-1:0] e_q;
	logic        [CCW-1:0] chunk_q;
	logic        [DCW-1:0] dcnt_q;
	logic        [AW-1:0]  ua_q;
	logic        [MW-1:0]  ub_q;
	logic                  neg_q;
	logic        [2*MW-1:0] pp_q;
	logic        [DW-1:0]  prod_q;
	logic        [RW-1:0]  rem_q;
	logic signed [SW-1:0]  sum_q;

	logic                 accept;
	logic                 go;
	logic signed [EW-1:0] a_rd;
	logic signed [OW-1:0] b_rd;
	logic        [EW-1:0] a_mag;
	logic        [OW-1:0] b_mag;
	logic        [MW-1:0] a_chunk;
	logic        [RW-1:0] dv_rem;
	logic        [DW-1:0] dv_val;
	logic        [TW-1:0] dv_t;
	logic signed [SW-1:0] q_term;
	logic signed [SW-1:0] smax;
	logic signed [SW-1:0] smin;
	logic signed [EW-1:0] sat_v;
	logic signed [XW-1:0] emax;
	logic signed [XW-1:0] emin;
	logic signed [XW-1:0] omax;
	logic signed [XW-1:0] omin;
	logic signed [EW-1:0] copy_v [amcm_pkg::MAT_SIZE];
	logic signed [XW-1:0] out_x;
	logic signed [OW-1:0] out_v;

	assign accept = start && !busy;
	assign go     = accept && (cnt_q == IW'(amcm_pkg::MAT_SIZE - 1));

	amcm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.go_copy (first_matrix),
		.stat    (stat),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	assign stat.mul_more  = (chunk_q != CCW'(NC - 1));
	assign stat.div_more  = (dcnt_q != DCW'(DSTEPS - 1));
	assign stat.k_more    = (k_q != 2'(amcm_pkg::ROWS - 1));
	assign stat.ent_more  = !((r_q == 2'(amcm_pkg::ROWS - 1)) && (c_q == 2'(amcm_pkg::COLS - 1)));
	assign stat.emit_more = (e_q != IW'(amcm_pkg::MAT_SIZE - 1));
	assign stat.last      = last_q;

	assign a_rd    = (ctrl.op == amcm_pkg::OP_OFS) ? acc_q[{r_q, 2'b11}] : acc_q[{r_q, k_q}];
	assign b_rd    = inc_q[{k_q, c_q}];
	assign a_mag   = a_rd[EW-1] ? EW'(-a_rd) : EW'(a_rd);
	assign b_mag   = b_rd[OW-1] ? OW'(-b_rd) : OW'(b_rd);
	assign a_chunk = MW'(ua_q >> (MW * int'(chunk_q)));

	always_comb begin
		dv_rem = rem_q;
		dv_val = prod_q;
		dv_t   = '0;
		for (int i = 0; i < DB; i++) begin
			dv_t   = {dv_rem, dv_val[DW-1]};
			dv_val = {dv_val[DW-2:0], 1'b0};
			if (dv_t >= TW'(amcm_pkg::FIX_SCALE)) begin
				dv_rem    = RW'(dv_t - TW'(amcm_pkg::FIX_SCALE));
				dv_val[0] = 1'b1;
			end else begin
				dv_rem = RW'(dv_t);
			end
		end
	end

	assign q_term = SW'(prod_q);
	assign smax   = {{(SW - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
	assign smin   = ~smax;
	assign sat_v  = (sum_q > smax) ? EW'(smax) : ((sum_q < smin) ? EW'(smin) : EW'(sum_q));

	assign emax = {{(XW - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
	assign emin = ~emax;
	assign omax = {{(XW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
	assign omin = ~omax;

	always_comb begin
		for (int i = 0; i < amcm_pkg::MAT_SIZE; i++) begin
			if (XW'(inc_q[i]) > emax) begin
				copy_v[i] = EW'(emax);
			end else if (XW'(inc_q[i]) < emin) begin
				copy_v[i] = EW'(emin);
			end else begin
				copy_v[i] = EW'(inc_q[i]);
			end
		end
	end

	assign out_x = XW'(acc_q[e_q]);
	assign out_v = (out_x > omax) ? OW'(omax) : ((out_x < omin) ? OW'(omin) : OW'(out_x));

	always_ff @(posedge clk) begin
		if (accept) begin
			inc_q[cnt_q] <= element;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= '0;
			last_q <= last_matrix;
		end else if (accept) begin
			cnt_q <= IW'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amcm_pkg::MAT_SIZE; i++) begin
				acc_q[i] <= '0;
			end
		end else if (ctrl.op == amcm_pkg::OP_COPY) begin
			for (int i = 0; i < amcm_pkg::MAT_SIZE; i++) begin
				acc_q[i] <= copy_v[i];
			end
		end else if (ctrl.op == amcm_pkg::OP_STORE && c_q == 2'(amcm_pkg::COLS - 1)) begin
			for (int i = 0; i < amcm_pkg::ROWS; i++) begin
				acc_q[{r_q, 2'(i)}] <= row_q[i];
			end
			acc_q[{r_q, 2'b11}] <= sat_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			e_q     <= '0;
			chunk_q <= '0;
			dcnt_q  <= '0;
		end else begin
			case (ctrl.op)
				amcm_pkg::OP_INIT: begin
					r_q <= '0;
					c_q <= '0;
					k_q <= '0;
				end
				amcm_pkg::OP_LOAD: begin
					chunk_q <= '0;
					dcnt_q  <= '0;
				end
				amcm_pkg::OP_ACC: begin
					chunk_q <= CCW'(chunk_q + 1'b1);
				end
				amcm_pkg::OP_DIV: begin
					dcnt_q <= DCW'(dcnt_q + 1'b1);
				end
				amcm_pkg::OP_TERM: begin
					k_q <= 2'(k_q + 1'b1);
				end
				amcm_pkg::OP_STORE: begin
					k_q <= '0;
					if (c_q == 2'(amcm_pkg::COLS - 1)) begin
						c_q <= '0;
						r_q <= 2'(r_q + 1'b1);
					end else begin
						c_q <= 2'(c_q + 1'b1);
					end
				end
				amcm_pkg::OP_EMIT_INIT: begin
					e_q <= '0;
				end
				amcm_pkg::OP_EMIT: begin
					e_q <= IW'(e_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			amcm_pkg::OP_INIT: begin
				sum_q <= '0;
			end
			amcm_pkg::OP_LOAD: begin
				ua_q   <= AW'(a_mag);
				ub_q   <= MW'(b_mag);
				neg_q  <= a_rd[EW-1] ^ b_rd[OW-1];
				prod_q <= '0;
				rem_q  <= '0;
			end
			amcm_pkg::OP_MUL: begin
				pp_q <= (2 * MW)'(a_chunk) * (2 * MW)'(ub_q);
			end
			amcm_pkg::OP_ACC: begin
				prod_q <= prod_q + (DW'(pp_q) << (MW * int'(chunk_q)));
			end
			amcm_pkg::OP_DIV: begin
				prod_q <= dv_val;
				rem_q  <= dv_rem;
			end
			amcm_pkg::OP_TERM: begin
				sum_q <= neg_q ? (sum_q - q_term) : (sum_q + q_term);
			end
			amcm_pkg::OP_OFS: begin
				if (c_q == 2'(amcm_pkg::COLS - 1)) begin
					sum_q <= sum_q + SW'(a_rd);
				end
			end
			amcm_pkg::OP_STORE: begin
				sum_q <= '0;
				if (c_q != 2'(amcm_pkg::COLS - 1)) begin
					row_q[c_q] <= sat_v;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= (ctrl.op == amcm_pkg::OP_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == amcm_pkg::OP_EMIT) begin
			entry       <= out_v;
			entry_index <= e_q;
			last_entry  <= (e_q == IW'(amcm_pkg::MAT_SIZE - 1));
		end
	end

	// A result beat only appears while the sequencer is still running.
	`AMCM_ASSERT(a_strobe_busy, strobe |-> busy, "result beat outside of a busy period")
	`AMCM_ASSERT(a_last_index, (strobe && last_entry) |-> (entry_index == IW'(amcm_pkg::MAT_SIZE - 1)), "last beat with wrong index")
	`AMCM_ASSERT(a_beat_order, (strobe && !last_entry) |=> (strobe && (entry_index == IW'($past(entry_index) + 1'b1))), "result beats out of order")
	`AMCM_ASSERT_NEVER(a_cnt_range, cnt_q > IW'(amcm_pkg::MAT_SIZE - 1), "element counter out of range")

endmodule
